[rtl/seven_segment_serial_framer_core_macros.svh]
// Assertion macros shared by the framer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SEVEN_SEGMENT_SERIAL_FRAMER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_FRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSF_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("ssf assertion failed");

// next-cycle implication
`define SSF_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("ssf assertion failed");

`else

`define SSF_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define SSF_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[rtl/ssf_pkg.sv]
// Shared types, constants and functions of the seven-segment serial framer.
// No dependencies.
package ssf_pkg;

  localparam int NUM_W   = 16;
  localparam int POINT_W = 2;
  localparam int REM_W   = 20;   // holds 8 * 10^5 and 10^6 - 1
  localparam int PLACE_W = 3;    // digit index, up to six digits
  localparam int WBIT_W  = 2;    // restoring step within one digit

  localparam logic [3:0] BLANK_DIGIT = 4'd10;

  typedef struct packed {
    logic               load;
    logic               div_en;
    logic [PLACE_W-1:0] place;
    logic [WBIT_W-1:0]  wbit;
    logic               build;
    logic               shift;
  } ssf_cmd_t;

  typedef struct packed {
    logic last_bit;
  } ssf_status_t;

  // segment pattern, a..g in bits 7..1, bit 0 unused
  function automatic logic [7:0] seg_pattern_f(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'b11111100;
      4'd1:    pat = 8'b01100000;
      4'd2:    pat = 8'b11011010;
      4'd3:    pat = 8'b11110010;
      4'd4:    pat = 8'b01100110;
      4'd5:    pat = 8'b10110110;
      4'd6:    pat = 8'b10111110;
      4'd7:    pat = 8'b11100000;
      4'd8:    pat = 8'b11111110;
      4'd9:    pat = 8'b11110110;
      default: pat = 8'b00000000;
    endcase
    return pat;
  endfunction

  function automatic logic [REM_W-1:0] pow10_f(input logic [PLACE_W-1:0] p);
    logic [REM_W-1:0] w;
    case (p)
      3'd0:    w = REM_W'(1);
      3'd1:    w = REM_W'(10);
      3'd2:    w = REM_W'(100);
      3'd3:    w = REM_W'(1000);
      3'd4:    w = REM_W'(10000);
      3'd5:    w = REM_W'(100000);
      3'd6:    w = REM_W'(1000000);
      default: w = REM_W'(1);
    endcase
    return w;
  endfunction

endpackage

[rtl/ssf_ctrl.sv]
// Sequencer of the framer: accept, digit conversion steps, frame build, send.
// Depends on ssf_pkg and seven_segment_serial_framer_core_macros.svh.
`include "seven_segment_serial_framer_core_macros.svh"

module ssf_ctrl import ssf_pkg::*; #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output ssf_cmd_t    cmd_o,
  input  ssf_status_t status_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;
  localparam logic [1:0] ST_SEND  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [PLACE_W-1:0] place_q, place_d;
  logic [WBIT_W-1:0]  wbit_q, wbit_d;

  always_comb begin
    state_d      = state_q;
    place_d      = place_q;
    wbit_d       = wbit_q;
    s_tready_o   = 1'b0;
    m_tvalid_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.place  = place_q;
    cmd_o.wbit   = wbit_q;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          place_d    = PLACE_W'(DIGIT_COUNT - 1);
          wbit_d     = '1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.div_en = 1'b1;
        wbit_d       = wbit_q - 1'b1;
        if (wbit_q == '0) begin
          if (place_q == '0) begin
            state_d = ST_BUILD;
          end else begin
            place_d = place_q - 1'b1;
          end
        end
      end
      ST_BUILD: begin
        cmd_o.build = 1'b1;
        state_d     = ST_SEND;
      end
      ST_SEND: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          cmd_o.shift = 1'b1;
          if (status_i.last_bit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      place_q <= '0;
      wbit_q  <= '0;
    end else begin
      state_q <= state_d;
      place_q <= place_d;
      wbit_q  <= wbit_d;
    end
  end

  `SSF_ASSERT_IMPLY(a_one_side, clk_i, rst_ni, s_tready_o, !m_tvalid_o)
  `SSF_ASSERT_NEXT(a_load_conv, clk_i, rst_ni, s_tvalid_i && s_tready_o,
    cmd_o.div_en && cmd_o.place == PLACE_W'(DIGIT_COUNT - 1) && cmd_o.wbit == '1)
  `SSF_ASSERT_NEXT(a_frame_done, clk_i, rst_ni,
    m_tvalid_o && m_tready_i && status_i.last_bit, s_tready_o)

endmodule

[rtl/ssf_datapath.sv]
// Framer datapath: saturation, restoring digit conversion, frame register.
// Depends on ssf_pkg.
module ssf_datapath import ssf_pkg::*; #(
  parameter int DIGIT_COUNT = 3,
  parameter int FRAME_BITS  = 36
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssf_cmd_t           cmd_i,
  output ssf_status_t        status_o,
  input  logic               op_i,
  input  logic [NUM_W-1:0]   number_value_i,
  input  logic [POINT_W-1:0] point_position_i,
  output logic               serial_bit_o
);

  localparam int BL_W = $clog2(FRAME_BITS + 1);
  localparam logic [REM_W-1:0] LIMIT = pow10_f(PLACE_W'(DIGIT_COUNT)) - 1'b1;

  logic                  op_q;
  logic [POINT_W-1:0]    point_q;
  logic [REM_W-1:0]      rem_q, rem_d, num_ext, weight;
  logic                  ge;
  logic [3:0]            digits_q [DIGIT_COUNT];
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [BL_W-1:0]       bits_left_q;

  assign num_ext = {{(REM_W - NUM_W){1'b0}}, number_value_i};
  assign weight  = pow10_f(cmd_i.place) << cmd_i.wbit;
  assign ge      = rem_q >= weight;

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.load) begin
      rem_d = (num_ext > LIMIT) ? LIMIT : num_ext;
    end else if (cmd_i.div_en && ge) begin
      rem_d = rem_q - weight;
    end
  end

  // start bit, digits from the highest place down, spare zeros, latch zero
  always_comb begin
    logic [7:0] pat;
    logic       pt;
    frame_d                 = '0;
    frame_d[FRAME_BITS-1]   = 1'b1;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      pat = op_q ? seg_pattern_f(BLANK_DIGIT) : seg_pattern_f(digits_q[i]);
      pt  = !op_q && (int'(point_q) == i + 1);
      frame_d[FRAME_BITS - 2 - 8 * (DIGIT_COUNT - 1 - i) -: 8] = {pat[7:1], pt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      point_q <= point_position_i;
    end
    rem_q <= rem_d;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (cmd_i.div_en && cmd_i.place == PLACE_W'(i)) begin
        digits_q[i][cmd_i.wbit] <= ge;
      end
    end
    if (cmd_i.build) begin
      frame_q <= frame_d;
    end else if (cmd_i.shift) begin
      frame_q <= frame_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_left_q <= '0;
    end else if (cmd_i.build) begin
      bits_left_q <= BL_W'(FRAME_BITS);
    end else if (cmd_i.shift) begin
      bits_left_q <= bits_left_q - 1'b1;
    end
  end

  assign serial_bit_o      = frame_q[FRAME_BITS-1];
  assign status_o.last_bit = bits_left_q == BL_W'(1);

endmodule

[rtl/seven_segment_serial_framer_core.sv]
// Seven-segment serial framer top level: sequencer plus datapath.
// Depends on ssf_pkg, ssf_ctrl and ssf_datapath.
//
//   channel  dir  tdata                           tuser / tlast
//   s_axis   in   [15:0] number, [17:16] point    tuser: op (1 = blank)
//   m_axis   out  [0] serial bit                  tlast: latch bit
//
// An item runs through an accept state, four restoring steps per digit on one
// shared subtract-compare unit, a frame build state, then one bit per cycle
// while m_axis_tready_i is high.
// Reset leaves the block idle with no bits pending.
// A low m_axis_tready_i holds the current bit; no input is taken mid-frame.
module seven_segment_serial_framer_core import ssf_pkg::*; #(
  parameter int DIGIT_COUNT = 3,
  parameter int SPARE_BITS  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [15:0] number_value, [17:16] point_position
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [0] serial_bit
  output logic        m_axis_tlast_o    // frame_end
);

  localparam int FRAME_BITS = 2 + 8 * DIGIT_COUNT + SPARE_BITS;

  ssf_cmd_t    cmd;
  ssf_status_t status;
  logic        serial_bit;

  ssf_ctrl #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ssf_datapath #(
    .DIGIT_COUNT(DIGIT_COUNT),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .op_i             (s_axis_tuser_i),
    .number_value_i   (s_axis_tdata_i[15:0]),
    .point_position_i (s_axis_tdata_i[17:16]),
    .serial_bit_o     (serial_bit)
  );

  assign m_axis_tdata_o = {7'b0, serial_bit};
  assign m_axis_tlast_o = status.last_bit;

endmodule

[tb/sv/seven_segment_serial_framer_core_test.sv]
// Testbench for seven_segment_serial_framer_core: requests go in, every serial word is checked.
// A scoreboard class predicts the 36-bit frame of each request and compares it bit by bit.
// Depends on the framer RTL; no files or arguments.
module seven_segment_serial_framer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN   = 36;
  localparam int SPARE_LEN   = 10;
  localparam int MAX_SHOWN   = 999;
  localparam int DRAIN_WAIT  = 60;
  localparam int RANDOM_REQS = 420;

  typedef enum bit {OP_SHOW = 1'b0, OP_BLANK = 1'b1} framer_op_e;

  // a..g in bits 7..1, index is the digit
  localparam bit [9:0][7:0] SEG_CODES = {
    8'hF6, 8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  class seg_frame_scoreboard;
    typedef struct packed {
      bit serial;
      bit last;
    } frame_word_t;

    frame_word_t pending_words[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned requests;
    int unsigned blanks;
    int unsigned saturated;

    function void note_request(framer_op_e op, bit [15:0] number, bit [1:0] point);
      int unsigned shown;
      bit [3:0] digits [1:3];
      bit [7:0] code;
      frame_word_t w;
      requests++;
      shown = 32'(number);
      if (shown > MAX_SHOWN) begin
        shown = MAX_SHOWN;
        saturated++;
      end
      digits[3] = 4'(shown / 100);
      digits[2] = 4'((shown / 10) % 10);
      digits[1] = 4'(shown % 10);
      if (op == OP_BLANK) blanks++;
      w.last = 1'b0;
      w.serial = 1'b1;
      pending_words.push_back(w);
      for (int place = 3; place >= 1; place--) begin
        code = (op == OP_BLANK) ? 8'h00 : SEG_CODES[digits[place]];
        for (int s = 7; s >= 1; s--) begin
          w.serial = code[s];
          pending_words.push_back(w);
        end
        w.serial = (op == OP_SHOW) && (point == place);
        pending_words.push_back(w);
      end
      w.serial = 1'b0;
      repeat (SPARE_LEN) pending_words.push_back(w);
      w.last = 1'b1;
      pending_words.push_back(w);
    endfunction

    function void check_word(bit serial, bit last);
      frame_word_t exp_w;
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        $error("unexpected word: serial_bit %0b, frame_end %0b", serial, last);
        return;
      end
      exp_w = pending_words.pop_front();
      if (exp_w.serial !== serial) begin
        mismatches++;
        $error("serial_bit: expected %0b, got %0b", exp_w.serial, serial);
      end
      if (exp_w.last !== last) begin
        mismatches++;
        $error("frame_end: expected %0b, got %0b", exp_w.last, last);
      end
    endfunction

    function bit busy();
      return pending_words.size() != 0;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;  // [15:0] number_value, [17:16] point_position
  logic        s_axis_tuser_i = 1'b0; // [0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [7:0]  m_axis_tdata_o;       // [0] serial_bit
  logic        m_axis_tlast_o;       // frame_end

  seg_frame_scoreboard sb;
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  seven_segment_serial_framer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #15ms;
    $display("** seven_segment_serial_framer_core: FAILED **");
    $finish;
  end

  // receiver stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_word(m_axis_tdata_o[0], m_axis_tlast_o);
  end

  task automatic issue_request(framer_op_e op, bit [15:0] number, bit [1:0] point);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, point, number};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, number, point);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 24'($urandom);
      s_axis_tuser_i  <= 1'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic drain_frames();
    s_axis_tvalid_i <= 1'b0;
    while (sb.busy()) @(posedge clk_i);
  endtask

  task automatic random_request();
    framer_op_e op;
    bit [15:0]  number;
    int unsigned pick;
    op   = ($urandom_range(0, 6) == 0) ? OP_BLANK : OP_SHOW;
    pick = $urandom_range(0, 9);
    if (pick < 4)      number = 16'($urandom_range(0, 65535));
    else if (pick < 9) number = 16'($urandom_range(0, MAX_SHOWN));
    else               number = 16'($urandom_range(990, 1010));
    issue_request(op, number, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every digit, every point place, saturation, blanking
    issue_request(OP_SHOW, 16'd0, 2'd0);
    issue_request(OP_SHOW, 16'd999, 2'd3);
    issue_request(OP_SHOW, 16'd1000, 2'd2);
    issue_request(OP_SHOW, 16'hFFFF, 2'd1);
    issue_request(OP_SHOW, 16'd123, 2'd1);
    issue_request(OP_SHOW, 16'd456, 2'd2);
    issue_request(OP_SHOW, 16'd789, 2'd3);
    issue_request(OP_SHOW, 16'd102, 2'd0);
    issue_request(OP_SHOW, 16'd5, 2'd3);
    issue_request(OP_SHOW, 16'd10, 2'd2);
    issue_request(OP_SHOW, 16'd100, 2'd1);
    issue_request(OP_SHOW, 16'd998, 2'd0);
    issue_request(OP_SHOW, 16'h8000, 2'd2);
    issue_request(OP_SHOW, 16'h5555, 2'd1);
    issue_request(OP_SHOW, 16'h2AA, 2'd2);
    issue_request(OP_BLANK, 16'd0, 2'd0);
    issue_request(OP_BLANK, 16'hFFFF, 2'd3);
    issue_request(OP_BLANK, 16'd888, 2'd1);
    issue_request(OP_BLANK, 16'd1, 2'd2);
    issue_request(OP_SHOW, 16'd888, 2'd3);
    drain_frames();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 140 || i == 280 || i == 360) drain_frames();
      if (i >= 360) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else if (i >= 140) begin
        gaps_on   = ((i / 20) % 2) == 0;
        stalls_on = ((i / 30) % 2) == 1;
      end
      random_request();
    end

    drain_frames();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d requests (%0d blank, %0d saturated), %0d serial words checked.",
             sb.requests, sb.blanks, sb.saturated, sb.words_checked);
    if (sb.mismatches == 0 && !sb.busy()) begin
      $display("** seven_segment_serial_framer_core: PASSED **");
    end else begin
      $display("** seven_segment_serial_framer_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ssf_pkg.sv
rtl/ssf_ctrl.sv
rtl/ssf_datapath.sv
rtl/seven_segment_serial_framer_core.sv
tb/sv/seven_segment_serial_framer_core_test.sv
